/* hw/rtl/rpa_pkg.sv */
// ----------------------------------------------------------------------------
// rpa_pkg: shared constants and the arctangent table function for the point rotator
// Fixed-point constants for the CORDIC and the rotation matrix.
// ----------------------------------------------------------------------------
package rpa_pkg;

  localparam int AtanEntries = 24;
  localparam logic signed [35:0] GainQ30   = 36'sd652032874;
  localparam logic signed [35:0] PiQ30     = 36'sd3373259426;
  localparam logic signed [35:0] HalfPiQ30 = 36'sd1686629713;
  localparam logic signed [35:0] OneQ30    = 36'sd1073741824;

  function automatic logic signed [35:0] atan_q30(input logic [4:0] idx);
    logic signed [35:0] r;
    case (idx)
      5'd0:  r = 36'sd843314856;
      5'd1:  r = 36'sd497837829;
      5'd2:  r = 36'sd263043836;
      5'd3:  r = 36'sd133525158;
      5'd4:  r = 36'sd67021686;
      5'd5:  r = 36'sd33543515;
      5'd6:  r = 36'sd16775850;
      5'd7:  r = 36'sd8388437;
      5'd8:  r = 36'sd4194282;
      5'd9:  r = 36'sd2097149;
      5'd10: r = 36'sd1048575;
      5'd11: r = 36'sd524287;
      5'd12: r = 36'sd262143;
      5'd13: r = 36'sd131071;
      5'd14: r = 36'sd65535;
      5'd15: r = 36'sd32767;
      5'd16: r = 36'sd16383;
      5'd17: r = 36'sd8191;
      5'd18: r = 36'sd4095;
      5'd19: r = 36'sd2047;
      5'd20: r = 36'sd1023;
      5'd21: r = 36'sd511;
      5'd22: r = 36'sd255;
      5'd23: r = 36'sd127;
      default: r = 36'sd0;
    endcase
    return r;
  endfunction

endpackage

/* hw/rtl/rotate_point_about_axis_core.sv */
// ----------------------------------------------------------------------------
// rotate_point_about_axis_core: rotates a 3-D point about a unit axis
// Axis-angle (Rodrigues) rotation with a pipelined CORDIC for sin and cos.
// ----------------------------------------------------------------------------
// Usage: an input word carries a Q16.16 point, a Q2.14 unit axis and a Q3.13
// angle in radians. It is taken when in_valid and in_ready are both high.
// One output word with the rotated point, rounded and saturated to Q16.16,
// leaves on the out channel when out_valid and out_ready are both high.
// The block is one pipeline: a fold stage, CORDIC_STEPS CORDIC stages (capped
// at AtanEntries), then six stages that form and round the matrix entries and
// apply them to the point. One word is taken per cycle unless the receiver
// stalls; every stage holds one word.
// A stall of the receiver freezes the whole pipeline at once (in_ready is
// out_ready or an empty output stage), so no word is lost or repeated; a
// bubble in the output stage is filled while the receiver waits.
// Reset clears every valid bit; data registers are not reset.
// The multiplier widths are kept near 32 by 32; the 61-bit products of the
// matrix application are split into two partial products over two stages.
// ----------------------------------------------------------------------------
module rotate_point_about_axis_core
  import rpa_pkg::*;
#(
  parameter int CORDIC_STEPS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] point_x,
  input  logic signed [31:0] point_y,
  input  logic signed [31:0] point_z,
  input  logic signed [15:0] axis_x,
  input  logic signed [15:0] axis_y,
  input  logic signed [15:0] axis_z,
  input  logic signed [15:0] angle,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] rotated_x,
  output logic signed [31:0] rotated_y,
  output logic signed [31:0] rotated_z
);

  localparam int NSteps = (CORDIC_STEPS < AtanEntries) ? CORDIC_STEPS : AtanEntries;
  // Stage count: fold, NSteps CORDIC, then entries e1..e3, apply a1..a3.
  localparam int NStages = NSteps + 7;

  logic adv;
  logic [NStages-1:0] vld;

  assign out_valid = vld[NStages-1];
  assign adv       = out_ready | ~vld[NStages-1];
  assign in_ready  = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[NStages-2:0], in_valid};
    end
  end

  // Point and axis ride along the CORDIC stages.
  logic signed [31:0] px [NSteps+1];
  logic signed [31:0] py [NSteps+1];
  logic signed [31:0] pz [NSteps+1];
  logic signed [15:0] nx [NSteps+1];
  logic signed [15:0] ny [NSteps+1];
  logic signed [15:0] nz [NSteps+1];
  logic               flp[NSteps+1];
  logic signed [35:0] cx [NSteps+1];
  logic signed [35:0] cy [NSteps+1];
  logic signed [35:0] cz [NSteps+1];

  // Fold stage: widen angle to Q.30 and fold into [-pi/2, pi/2].
  logic signed [35:0] ang_w;
  assign ang_w = 36'(angle) <<< 17;

  always_ff @(posedge clk) begin
    if (adv) begin
      px[0] <= point_x;
      py[0] <= point_y;
      pz[0] <= point_z;
      nx[0] <= axis_x;
      ny[0] <= axis_y;
      nz[0] <= axis_z;
      cx[0] <= GainQ30;
      cy[0] <= '0;
      if (ang_w > HalfPiQ30) begin
        cz[0] <= ang_w - PiQ30;
        flp[0] <= 1'b1;
      end else if (ang_w < -HalfPiQ30) begin
        cz[0] <= ang_w + PiQ30;
        flp[0] <= 1'b1;
      end else begin
        cz[0] <= ang_w;
        flp[0] <= 1'b0;
      end
    end
  end

  // One CORDIC iteration per stage.
  for (genvar i = 0; i < NSteps; i++) begin : g_cordic
    logic signed [35:0] xs, ys;
    assign xs = cx[i] >>> i;
    assign ys = cy[i] >>> i;
    always_ff @(posedge clk) begin
      if (adv) begin
        px[i+1] <= px[i];
        py[i+1] <= py[i];
        pz[i+1] <= pz[i];
        nx[i+1] <= nx[i];
        ny[i+1] <= ny[i];
        nz[i+1] <= nz[i];
        flp[i+1] <= flp[i];
        if (cz[i] >= 0) begin
          cx[i+1] <= cx[i] - ys;
          cy[i+1] <= cy[i] + xs;
          cz[i+1] <= cz[i] - atan_q30(5'(i));
        end else begin
          cx[i+1] <= cx[i] + ys;
          cy[i+1] <= cy[i] - xs;
          cz[i+1] <= cz[i] + atan_q30(5'(i));
        end
      end
    end
  end

  // Stage e1: signs applied, axis products, q*s products.
  // 1 - cos reaches 2^31 near an angle of pi, so it gets two extra bits.
  logic signed [31:0] c1;
  logic signed [33:0] omc1;
  logic signed [31:0] p_xx, p_yy, p_zz, p_xy, p_xz, p_yz;
  logic signed [47:0] u_x, u_y, u_z;
  logic signed [31:0] e_px, e_py, e_pz;
  logic signed [31:0] c_fin, s_fin;

  assign c_fin = 32'(flp[NSteps] ? -cx[NSteps] : cx[NSteps]);
  assign s_fin = 32'(flp[NSteps] ? -cy[NSteps] : cy[NSteps]);

  always_ff @(posedge clk) begin
    if (adv) begin
      c1   <= c_fin;
      omc1 <= 34'(OneQ30) - 34'(c_fin);
      p_xx <= 32'(nx[NSteps]) * 32'(nx[NSteps]);
      p_yy <= 32'(ny[NSteps]) * 32'(ny[NSteps]);
      p_zz <= 32'(nz[NSteps]) * 32'(nz[NSteps]);
      p_xy <= 32'(nx[NSteps]) * 32'(ny[NSteps]);
      p_xz <= 32'(nx[NSteps]) * 32'(nz[NSteps]);
      p_yz <= 32'(ny[NSteps]) * 32'(nz[NSteps]);
      u_x  <= 48'(nx[NSteps]) * 48'(s_fin);
      u_y  <= 48'(ny[NSteps]) * 48'(s_fin);
      u_z  <= 48'(nz[NSteps]) * 48'(s_fin);
      e_px <= px[NSteps];
      e_py <= py[NSteps];
      e_pz <= pz[NSteps];
    end
  end

  // Stage e2: p*(1-c) products, rounded to Q.30; q*s rounded.
  function automatic logic signed [34:0] rnd28(input logic signed [63:0] v);
    logic signed [63:0] t;
    t = (v + 64'sd134217728) >>> 28;
    return 35'(t);
  endfunction
  function automatic logic signed [33:0] rnd14(input logic signed [47:0] v);
    logic signed [47:0] t;
    t = (v + 48'sd8192) >>> 14;
    return 34'(t);
  endfunction

  logic signed [34:0] t_xx, t_yy, t_zz, t_xy, t_xz, t_yz;
  logic signed [33:0] r_x, r_y, r_z;
  logic signed [31:0] c2;
  logic signed [31:0] f_px, f_py, f_pz;

  always_ff @(posedge clk) begin
    if (adv) begin
      t_xx <= rnd28(64'(p_xx) * 64'(omc1));
      t_yy <= rnd28(64'(p_yy) * 64'(omc1));
      t_zz <= rnd28(64'(p_zz) * 64'(omc1));
      t_xy <= rnd28(64'(p_xy) * 64'(omc1));
      t_xz <= rnd28(64'(p_xz) * 64'(omc1));
      t_yz <= rnd28(64'(p_yz) * 64'(omc1));
      r_x  <= rnd14(u_x);
      r_y  <= rnd14(u_y);
      r_z  <= rnd14(u_z);
      c2   <= c1;
      f_px <= e_px;
      f_py <= e_py;
      f_pz <= e_pz;
    end
  end

  // Stage e3: combine and round entries to Q.24.
  function automatic logic signed [28:0] rnd6(input logic signed [35:0] v);
    logic signed [35:0] t;
    t = (v + 36'sd32) >>> 6;
    return 29'(t);
  endfunction

  logic signed [28:0] m00, m01, m02, m10, m11, m12, m20, m21, m22;
  logic signed [31:0] g_px, g_py, g_pz;

  always_ff @(posedge clk) begin
    if (adv) begin
      m00 <= rnd6(36'(t_xx) + 36'(c2));
      m01 <= rnd6(36'(t_xy) - 36'(r_z));
      m02 <= rnd6(36'(t_xz) + 36'(r_y));
      m10 <= rnd6(36'(t_xy) + 36'(r_z));
      m11 <= rnd6(36'(t_yy) + 36'(c2));
      m12 <= rnd6(36'(t_yz) - 36'(r_x));
      m20 <= rnd6(36'(t_xz) - 36'(r_y));
      m21 <= rnd6(36'(t_yz) + 36'(r_x));
      m22 <= rnd6(36'(t_zz) + 36'(c2));
      g_px <= f_px;
      g_py <= f_py;
      g_pz <= f_pz;
    end
  end

  // Stage a1: partial products, point split into high and low 16 bits.
  logic signed [28:0] mm [9];
  logic signed [31:0] pp [3];
  logic signed [45:0] ph [9];
  logic signed [45:0] pl [9];

  assign mm = '{m00, m01, m02, m10, m11, m12, m20, m21, m22};
  assign pp = '{g_px, g_py, g_pz};

  for (genvar k = 0; k < 9; k++) begin : g_part
    always_ff @(posedge clk) begin
      if (adv) begin
        ph[k] <= 46'(mm[k]) * 46'($signed(pp[k % 3][31:16]));
        pl[k] <= 46'(mm[k]) * 46'($signed({1'b0, pp[k % 3][15:0]}));
      end
    end
  end

  // Stage a2: recombine products and add each row.
  logic signed [63:0] rs [3];
  for (genvar r = 0; r < 3; r++) begin : g_row
    always_ff @(posedge clk) begin
      if (adv) begin
        rs[r] <= (64'(ph[3*r]) <<< 16) + 64'(pl[3*r])
               + (64'(ph[3*r+1]) <<< 16) + 64'(pl[3*r+1])
               + (64'(ph[3*r+2]) <<< 16) + 64'(pl[3*r+2]);
      end
    end
  end

  // Stage a3: round to Q16.16 and saturate.
  function automatic logic signed [31:0] sat(input logic signed [63:0] v);
    logic signed [63:0] t;
    t = (v + 64'sd8388608) >>> 24;
    if (t > 64'sd2147483647) begin
      return 32'sh7fffffff;
    end else if (t < -64'sd2147483648) begin
      return 32'sh80000000;
    end
    return 32'(t);
  endfunction

  always_ff @(posedge clk) begin
    if (adv) begin
      rotated_x <= sat(rs[0]);
      rotated_y <= sat(rs[1]);
      rotated_z <= sat(rs[2]);
    end
  end

endmodule
